FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/lsf_pkg.sv
package lsf_pkg;

    localparam int unsigned LSF_MAX_POINTS = 4096;
    localparam int unsigned LSF_X_BITS     = 16;
    localparam int unsigned LSF_Y_BITS     = 24;
    localparam int unsigned LSF_FRAC_BITS  = 16;

    localparam int unsigned LSF_OUT_W  = 48;
    localparam int unsigned LSF_QDEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_CLIP  = 2'd2
    } t_fit_status;

endpackage

FILE: hdl/least_squares_line_fit.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+------------------------------
// points    | i_x_value, i_y_value, i_last_point      | i_push & !o_full
// fit       | o_slope, o_intercept, o_fit_status      | i_pop & !o_empty
//
// Points: one transaction per cycle while o_full is low, into a two-stage multiply-accumulate front end.
// Fit: each set is worked in the back end (WW = Y+2X+2*clog2(MAX+1)+2, DW = WW+FRAC+2)
// by one shift-add multiplier and one restoring divider that handle one bit per cycle.
// Up to four finished sets wait in the queue between front and back end.
// Reset is synchronous and active low; it clears sums, queue and result valid.
// o_full rises only when the queue has no room for the sets already in flight.
module least_squares_line_fit
    import lsf_pkg::*;
#(
    parameter int unsigned MAX_POINTS = LSF_MAX_POINTS,
    parameter int unsigned X_BITS     = LSF_X_BITS,
    parameter int unsigned Y_BITS     = LSF_Y_BITS,
    parameter int unsigned FRAC_BITS  = LSF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic signed [X_BITS-1:0]    i_x_value,
    input  logic signed [Y_BITS-1:0]    i_y_value,
    input  logic                        i_last_point,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic signed [LSF_OUT_W-1:0] o_slope,
    output logic signed [LSF_OUT_W-1:0] o_intercept,
    output logic [1:0]                  o_fit_status
);
    localparam int unsigned CW     = $clog2(MAX_POINTS+1);
    localparam int unsigned SUMS_W = CW + (X_BITS+CW) + (Y_BITS+CW) + (2*X_BITS+CW)
                                     + (X_BITS+Y_BITS+CW) + 1;
    localparam int unsigned QCW    = $clog2(LSF_QDEPTH+1);

    logic                   in_acc;
    logic                   f_push;
    logic [SUMS_W-1:0]      f_sums;
    logic [1:0]             f_lasts;
    logic                   q_pop, q_empty;
    logic [SUMS_W-1:0]      q_head;
    logic [QCW-1:0]         q_count;
    logic                   out_valid;
    logic [LSF_OUT_W-1:0]   slope, icpt;

    assign in_acc = i_push & ~o_full;
    // sets still in the front pipeline have a reserved queue slot
    assign o_full = ((QCW+1)'(q_count) + (QCW+1)'(f_lasts)) >= (QCW+1)'(LSF_QDEPTH);

    lsf_front #(
        .MAX_POINTS (MAX_POINTS),
        .X_BITS     (X_BITS),
        .Y_BITS     (Y_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .i_x     (i_x_value),
        .i_y     (i_y_value),
        .i_last  (i_last_point),
        .o_push  (f_push),
        .o_sums  (f_sums),
        .o_lasts (f_lasts)
    );

    lsf_queue #(
        .DATA_W (SUMS_W),
        .DEPTH  (LSF_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_sums),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    lsf_back #(
        .MAX_POINTS (MAX_POINTS),
        .X_BITS     (X_BITS),
        .Y_BITS     (Y_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .i_out_pop    (i_pop & out_valid),
        .o_out_valid  (out_valid),
        .o_slope      (slope),
        .o_intercept  (icpt),
        .o_fit_status (o_fit_status)
    );

    assign o_empty     = ~out_valid;
    assign o_slope     = $signed(slope);
    assign o_intercept = $signed(icpt);
endmodule

FILE: hdl/lsf_queue.sv
module lsf_queue
    import lsf_pkg::*;
#(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = LSF_QDEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [DATA_W-1:0]            i_data,
    input  logic                         i_pop,
    output logic [DATA_W-1:0]            o_head,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH+1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
endmodule

FILE: hdl/lsf_front.sv
module lsf_front
    import lsf_pkg::*;
#(
    parameter int unsigned MAX_POINTS = LSF_MAX_POINTS,
    parameter int unsigned X_BITS     = LSF_X_BITS,
    parameter int unsigned Y_BITS     = LSF_Y_BITS,
    localparam int unsigned CW     = $clog2(MAX_POINTS+1),
    localparam int unsigned SUMS_W = CW + (X_BITS+CW) + (Y_BITS+CW) + (2*X_BITS+CW)
                                     + (X_BITS+Y_BITS+CW) + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [X_BITS-1:0] i_x,
    input  logic signed [Y_BITS-1:0] i_y,
    input  logic                     i_last,
    output logic                     o_push,
    output logic [SUMS_W-1:0]        o_sums,
    output logic [1:0]               o_lasts
);
    localparam int unsigned SX_W  = X_BITS + CW;
    localparam int unsigned SY_W  = Y_BITS + CW;
    localparam int unsigned SXX_W = 2*X_BITS + CW;
    localparam int unsigned SXY_W = X_BITS + Y_BITS + CW;

    // stage A: captured point
    logic                     r_a_v, r_a_last;
    logic signed [X_BITS-1:0] r_a_x;
    logic signed [Y_BITS-1:0] r_a_y;
    // stage B: products
    logic                            r_b_v, r_b_last;
    logic signed [X_BITS-1:0]        r_b_x;
    logic signed [Y_BITS-1:0]        r_b_y;
    logic signed [2*X_BITS-1:0]      r_b_xx;
    logic signed [X_BITS+Y_BITS-1:0] r_b_xy;
    // accumulators
    logic [CW-1:0]           r_cnt, n_cnt;
    logic signed [SX_W-1:0]  r_sx, n_sx;
    logic signed [SY_W-1:0]  r_sy, n_sy;
    logic signed [SXX_W-1:0] r_sxx, n_sxx;
    logic signed [SXY_W-1:0] r_sxy, n_sxy;
    logic                    r_drop, n_drop;

    always_ff @(posedge i_clk) begin
        r_a_x  <= i_x;
        r_a_y  <= i_y;
        r_b_x  <= r_a_x;
        r_b_y  <= r_a_y;
        r_b_xx <= r_a_x * r_a_x;
        r_b_xy <= r_a_x * r_a_y;
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_sxx  = r_sxx;
        n_sxy  = r_sxy;
        n_drop = r_drop;
        if (r_b_v) begin
            if (r_cnt < CW'(MAX_POINTS)) begin
                n_cnt = r_cnt + 1'b1;
                n_sx  = r_sx + SX_W'(r_b_x);
                n_sy  = r_sy + SY_W'(r_b_y);
                n_sxx = r_sxx + SXX_W'(r_b_xx);
                n_sxy = r_sxy + SXY_W'(r_b_xy);
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    assign o_push  = r_b_v & r_b_last;
    assign o_sums  = {n_cnt, n_sx, n_sy, n_sxx, n_sxy, n_drop};
    assign o_lasts = 2'(r_a_last) + 2'(r_b_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_a_last <= 1'b0;
            r_b_v    <= 1'b0;
            r_b_last <= 1'b0;
            r_cnt    <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxx    <= '0;
            r_sxy    <= '0;
            r_drop   <= 1'b0;
        end else begin
            r_a_v    <= i_valid;
            r_a_last <= i_valid & i_last;
            r_b_v    <= r_a_v;
            r_b_last <= r_a_last;
            if (o_push) begin
                // set pushed into the queue; start a fresh one
                r_cnt  <= '0;
                r_sx   <= '0;
                r_sy   <= '0;
                r_sxx  <= '0;
                r_sxy  <= '0;
                r_drop <= 1'b0;
            end else begin
                r_cnt  <= n_cnt;
                r_sx   <= n_sx;
                r_sy   <= n_sy;
                r_sxx  <= n_sxx;
                r_sxy  <= n_sxy;
                r_drop <= n_drop;
            end
        end
    end
endmodule

FILE: hdl/lsf_back.sv
module lsf_back
    import lsf_pkg::*;
#(
    parameter int unsigned MAX_POINTS = LSF_MAX_POINTS,
    parameter int unsigned X_BITS     = LSF_X_BITS,
    parameter int unsigned Y_BITS     = LSF_Y_BITS,
    parameter int unsigned FRAC_BITS  = LSF_FRAC_BITS,
    localparam int unsigned CW     = $clog2(MAX_POINTS+1),
    localparam int unsigned SUMS_W = CW + (X_BITS+CW) + (Y_BITS+CW) + (2*X_BITS+CW)
                                     + (X_BITS+Y_BITS+CW) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  logic [SUMS_W-1:0]    i_q_head,
    output logic                 o_q_pop,
    input  logic                 i_out_pop,
    output logic                 o_out_valid,
    output logic [LSF_OUT_W-1:0] o_slope,
    output logic [LSF_OUT_W-1:0] o_intercept,
    output logic [1:0]           o_fit_status
);
    localparam int unsigned SX_W  = X_BITS + CW;
    localparam int unsigned SY_W  = Y_BITS + CW;
    localparam int unsigned SXX_W = 2*X_BITS + CW;
    localparam int unsigned SXY_W = X_BITS + Y_BITS + CW;
    localparam int unsigned WW    = Y_BITS + 2*X_BITS + 2*CW + 2;
    localparam int unsigned DW    = WW + FRAC_BITS + 2;
    localparam int unsigned QW    = (DW > LSF_OUT_W + 1) ? DW : LSF_OUT_W + 1;
    localparam int unsigned MCW   = $clog2(WW+1);
    localparam int unsigned DCW   = $clog2(DW+1);
    // field offsets inside the packed set
    localparam int unsigned O_SXY = 1;
    localparam int unsigned O_SXX = O_SXY + SXY_W;
    localparam int unsigned O_SY  = O_SXX + SXX_W;
    localparam int unsigned O_SX  = O_SY + SY_W;
    localparam int unsigned O_CNT = O_SX + SX_W;
    localparam logic [QW-1:0] POS_LIM = QW'((49'd1 << (LSF_OUT_W-1)) - 49'd1);
    localparam logic [QW-1:0] NEG_LIM = QW'(49'd1 << (LSF_OUT_W-1));

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MSET = 6'b000010,
        S_MRUN = 6'b000100,
        S_CHK  = 6'b001000,
        S_DSET = 6'b010000,
        S_DRUN = 6'b100000
    } t_state;

    t_state r_state;

    logic signed [WW-1:0] r_n, r_sx, r_sy, r_sxx, r_sxy;
    logic                 r_drop;
    logic [2:0]           r_op;
    logic [MCW-1:0]       r_mcnt;
    logic [WW-1:0]        r_ma, r_mb, r_acc, n_acc;
    logic                 r_mneg;
    logic signed [WW-1:0] r_first, r_d, r_n1, r_n2, prod;
    logic signed [WW-1:0] op_a, op_b, num;
    logic [WW-1:0]        abs_a, abs_b, abs_num, abs_d;

    logic                 r_dsel, r_dneg, r_clip;
    logic [DCW-1:0]       r_dcnt;
    logic [DW-1:0]        r_nq, r_den, n_nq;
    logic [DW:0]          r_rem, rem2;
    logic                 ge;
    logic [QW-1:0]        qz;
    logic [LSF_OUT_W-1:0] mag, sat_res, r_slope;
    logic                 sat_clip;

    logic                 r_ov;
    logic [LSF_OUT_W-1:0] r_oslope, r_oint;
    t_fit_status          r_ostat;

    // multiplier operand selection
    always_comb begin
        case (r_op)
            3'd0:    begin op_a = r_n;  op_b = r_sxx; end
            3'd1:    begin op_a = r_sx; op_b = r_sx;  end
            3'd2:    begin op_a = r_n;  op_b = r_sxy; end
            3'd3:    begin op_a = r_sx; op_b = r_sy;  end
            3'd4:    begin op_a = r_sy; op_b = r_sxx; end
            default: begin op_a = r_sx; op_b = r_sxy; end
        endcase
    end

    assign abs_a   = op_a[WW-1] ? WW'(-op_a) : WW'(op_a);
    assign abs_b   = op_b[WW-1] ? WW'(-op_b) : WW'(op_b);
    assign n_acc   = r_mb[0] ? r_acc + r_ma : r_acc;
    assign prod    = r_mneg ? -$signed(n_acc) : $signed(n_acc);

    assign num     = r_dsel ? r_n2 : r_n1;
    assign abs_num = num[WW-1] ? WW'(-num) : WW'(num);
    assign abs_d   = r_d[WW-1] ? WW'(-r_d) : WW'(r_d);

    // restoring divider step
    assign rem2 = {r_rem[DW-1:0], r_nq[DW-1]};
    assign ge   = (rem2 >= {1'b0, r_den});
    assign n_nq = {r_nq[DW-2:0], ge};

    // saturation to the output width
    always_comb begin
        qz       = QW'(n_nq);
        sat_clip = 1'b0;
        if (r_dneg) begin
            if (qz > NEG_LIM) begin
                sat_clip = 1'b1;
                mag      = LSF_OUT_W'(NEG_LIM);
            end else begin
                mag = LSF_OUT_W'(qz);
            end
            sat_res = LSF_OUT_W'(0) - mag;
        end else begin
            if (qz > POS_LIM) begin
                sat_clip = 1'b1;
                mag      = LSF_OUT_W'(POS_LIM);
            end else begin
                mag = LSF_OUT_W'(qz);
            end
            sat_res = mag;
        end
    end

    assign o_q_pop = (r_state == S_IDLE) & ~i_q_empty & ~r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (i_out_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= S_MSET;
                    end
                end
                S_MSET: r_state <= S_MRUN;
                S_MRUN: begin
                    if (r_mcnt == MCW'(WW-1)) begin
                        r_state <= (r_op == 3'd5) ? S_CHK : S_MSET;
                    end
                end
                S_CHK: begin
                    if (r_d == '0) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DSET;
                    end
                end
                S_DSET: r_state <= S_DRUN;
                S_DRUN: begin
                    if (r_dcnt == DCW'(DW-1)) begin
                        if (r_dsel) begin
                            r_ov    <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_DSET;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n    <= WW'(i_q_head[O_CNT +: CW]);
                r_sx   <= WW'($signed(i_q_head[O_SX +: SX_W]));
                r_sy   <= WW'($signed(i_q_head[O_SY +: SY_W]));
                r_sxx  <= WW'($signed(i_q_head[O_SXX +: SXX_W]));
                r_sxy  <= WW'($signed(i_q_head[O_SXY +: SXY_W]));
                r_drop <= i_q_head[0];
                r_op   <= 3'd0;
                r_dsel <= 1'b0;
                r_clip <= 1'b0;
            end
            S_MSET: begin
                r_ma   <= abs_a;
                r_mb   <= abs_b;
                r_mneg <= op_a[WW-1] ^ op_b[WW-1];
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            S_MRUN: begin
                r_acc  <= n_acc;
                r_ma   <= {r_ma[WW-2:0], 1'b0};
                r_mb   <= {1'b0, r_mb[WW-1:1]};
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == MCW'(WW-1)) begin
                    r_op <= r_op + 1'b1;
                    if (!r_op[0]) begin
                        r_first <= prod;
                    end else begin
                        case (r_op[2:1])
                            2'd0:    r_d  <= r_first - prod;
                            2'd1:    r_n1 <= r_first - prod;
                            default: r_n2 <= r_first - prod;
                        endcase
                    end
                end
            end
            S_CHK: begin
                if (r_d == '0) begin
                    r_oslope <= '0;
                    r_oint   <= '0;
                    r_ostat  <= ST_DEGEN;
                end
            end
            S_DSET: begin
                // round to nearest: (|num| * 2^(F+1) + |d|) / (2 |d|)
                r_nq   <= (DW'(abs_num) << (FRAC_BITS + 1)) + DW'(abs_d);
                r_den  <= DW'(abs_d) << 1;
                r_dneg <= num[WW-1] ^ r_d[WW-1];
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_DRUN: begin
                r_rem  <= ge ? rem2 - {1'b0, r_den} : rem2;
                r_nq   <= n_nq;
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == DCW'(DW-1)) begin
                    if (!r_dsel) begin
                        r_slope <= sat_res;
                        r_clip  <= sat_clip;
                        r_dsel  <= 1'b1;
                    end else begin
                        r_oslope <= r_slope;
                        r_oint   <= sat_res;
                        r_ostat  <= (r_clip | sat_clip | r_drop) ? ST_CLIP : ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_ov;
    assign o_slope      = r_oslope;
    assign o_intercept  = r_oint;
    assign o_fit_status = r_ostat;
endmodule

FILE: hdl/lsf_checker.sv
`include "assert_macros.svh"

module lsf_checker
    import lsf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_pop,
    input logic                 o_empty,
    input logic [LSF_OUT_W-1:0] o_slope,
    input logic [LSF_OUT_W-1:0] o_intercept,
    input logic [1:0]           o_fit_status
);
    logic [2*LSF_OUT_W+1:0] out_bus;
    logic                   degen_out;
    logic                   zero_out;

    assign out_bus   = {o_slope, o_intercept, o_fit_status};
    assign degen_out = !o_empty && (o_fit_status == ST_DEGEN);
    assign zero_out  = (o_slope == '0) && (o_intercept == '0);

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(out_bus))
    `ASSERT_SAME(a_degen_zero, i_clk, i_rst_n, degen_out, zero_out)
    `ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $rose(i_rst_n), o_empty)
    `ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, !o_empty && i_pop, o_empty)
endmodule

bind least_squares_line_fit lsf_checker u_lsf_checker (.*);

FILE: test/least_squares_line_fit_tb.sv
`timescale 1ns / 100ps

module least_squares_line_fit_tb;
    import lsf_pkg::*;

    typedef logic signed [255:0] t_wide;

    // one fit transaction as seen on the result ports
    typedef struct packed {
        logic signed [LSF_OUT_W-1:0] slope;
        logic signed [LSF_OUT_W-1:0] intercept;
        t_fit_status                 status;
    } t_fit;

    // directed row: one point; known=1 means the fit is typed in below
    typedef struct packed {
        logic signed [LSF_X_BITS-1:0] x;
        logic signed [LSF_Y_BITS-1:0] y;
        logic                         last;
        logic                         known;
        t_fit                         fit;
    } t_point_row;

    localparam int NUM_DIR = 19;
    localparam logic signed [LSF_OUT_W-1:0] ONE_FX = 48'sd65536;
    localparam logic signed [LSF_OUT_W-1:0] HALF_FX = 48'sd32768;

    localparam t_fit FIT_NONE  = '{slope: '0, intercept: '0, status: ST_OK};
    localparam t_fit FIT_DEGEN = '{slope: '0, intercept: '0, status: ST_DEGEN};

    // short directed sets: single point, identity line, all x equal, field extremes,
    // saturation, half slope, rounding
    localparam t_point_row DIR_TAB [NUM_DIR] = '{
        '{x: 16'sd5,      y: 24'sd100,      last: 1'b1, known: 1'b1, fit: FIT_DEGEN},
        '{x: 16'sd0,      y: 24'sd0,        last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd1,      y: 24'sd1,        last: 1'b1, known: 1'b1,
          fit: '{slope: ONE_FX, intercept: '0, status: ST_OK}},
        '{x: 16'sd7,      y: 24'sd1,        last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd7,      y: -24'sd3,       last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd7,      y: 24'sd9,        last: 1'b1, known: 1'b1, fit: FIT_DEGEN},
        '{x: -16'sd32768, y: -24'sd8388608, last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd32767,  y: 24'sd8388607,  last: 1'b1, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd32767,  y: -24'sd8388608, last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd32766,  y: 24'sd8388607,  last: 1'b1, known: 1'b0, fit: FIT_NONE},
        '{x: -16'sd32768, y: 24'sd8388607,  last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: -16'sd32767, y: -24'sd8388608, last: 1'b1, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd0,      y: 24'sd0,        last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd2,      y: 24'sd1,        last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd4,      y: 24'sd2,        last: 1'b1, known: 1'b1,
          fit: '{slope: HALF_FX, intercept: '0, status: ST_OK}},
        '{x: -16'sd1,     y: 24'sd3,        last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd1,      y: -24'sd3,       last: 1'b0, known: 1'b0, fit: FIT_NONE},
        '{x: 16'sd3,      y: 24'sd1,        last: 1'b1, known: 1'b0, fit: FIT_NONE},
        '{x: -16'sd1,     y: -24'sd1,       last: 1'b1, known: 1'b1, fit: FIT_DEGEN}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_push;
    logic                         o_full;
    logic signed [LSF_X_BITS-1:0] i_x_value;
    logic signed [LSF_Y_BITS-1:0] i_y_value;
    logic                         i_last_point;
    logic                         o_empty;
    logic                         i_pop;
    logic signed [LSF_OUT_W-1:0]  o_slope;
    logic signed [LSF_OUT_W-1:0]  o_intercept;
    logic [1:0]                   o_fit_status;

    least_squares_line_fit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_last_point (i_last_point),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_slope      (o_slope),
        .o_intercept  (o_intercept),
        .o_fit_status (o_fit_status)
    );

    // running sums of the open set, held exactly
    int    set_count;
    t_wide sum_x, sum_y, sum_xx, sum_xy;
    bit    set_dropped;

    t_fit fit_q[$];       // fits still owed by the block, oldest first
    int   err_count;
    int   snd_idle_pct;
    int   rcv_idle_pct;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // one rounded fixed-point quotient, ties away from zero, saturated to 48 bits
    function automatic logic [LSF_OUT_W-1:0] fx_quotient(input t_wide num, input t_wide den,
                                                         inout bit clip);
        t_wide mag_n, mag_d, q;
        t_wide lim;
        bit    neg;
        begin
            neg   = (num < 0) != (den < 0);
            mag_n = (num < 0) ? -num : num;
            mag_d = (den < 0) ? -den : den;
            q     = ((mag_n <<< (LSF_FRAC_BITS + 1)) + mag_d) / (mag_d <<< 1);
            lim   = t_wide'(1) <<< (LSF_OUT_W - 1);
            if (neg) begin
                if (q > lim) begin
                    clip = 1'b1;
                    q    = lim;
                end
                q = -q;
            end else if (q > lim - 1) begin
                clip = 1'b1;
                q    = lim - 1;
            end
            return q[LSF_OUT_W-1:0];
        end
    endfunction

    // add one point to the open set; on the last point queue the owed fit
    task automatic fold_point(input logic signed [LSF_X_BITS-1:0] x,
                              input logic signed [LSF_Y_BITS-1:0] y, input logic last);
        t_wide xw, yw, n, den;
        t_fit  f;
        bit    clip;
        begin
            xw = x;
            yw = y;
            if (set_count < LSF_MAX_POINTS) begin
                set_count++;
                sum_x  += xw;
                sum_y  += yw;
                sum_xx += xw * xw;
                sum_xy += xw * yw;
            end else begin
                set_dropped = 1'b1;
            end
            if (last) begin
                n   = set_count;
                den = n * sum_xx - sum_x * sum_x;
                if (den == 0) begin
                    f = FIT_DEGEN;
                end else begin
                    clip        = set_dropped;
                    f.slope     = fx_quotient(n * sum_xy - sum_x * sum_y, den, clip);
                    f.intercept = fx_quotient(sum_y * sum_xx - sum_x * sum_xy, den, clip);
                    f.status    = clip ? ST_CLIP : ST_OK;
                end
                fit_q       = {fit_q, f};
                set_count   = 0;
                sum_x       = '0;
                sum_y       = '0;
                sum_xx      = '0;
                sum_xy      = '0;
                set_dropped = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [LSF_OUT_W-1:0] got,
                                   input logic [LSF_OUT_W-1:0] want);
        begin
            $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
            err_count++;
        end
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_point(input logic signed [LSF_X_BITS-1:0] x,
                              input logic signed [LSF_Y_BITS-1:0] y, input logic last);
        begin
            if ($urandom_range(99) < snd_idle_pct) begin
                i_push = 1'b0;
                do @(negedge i_clk); while ($urandom_range(99) < snd_idle_pct);
            end
            i_push       = 1'b1;
            i_x_value    = x;
            i_y_value    = y;
            i_last_point = last;
            do @(posedge i_clk); while (o_full);
            fold_point(x, y, last);
            @(negedge i_clk);
        end
    endtask

    // random sets; x spread picks between wide, narrow, constant, two adjacent values and extreme
    task automatic send_sets(input int n_items);
        int sent, len, mode, k;
        logic signed [LSF_X_BITS-1:0] x, x0;
        logic signed [LSF_Y_BITS-1:0] y;
        begin
            sent = 0;
            while (sent < n_items) begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
                mode = $urandom_range(4);
                x0   = LSF_X_BITS'($urandom);
                for (k = 0; k < len; k++) begin
                    case (mode)
                        0: x = LSF_X_BITS'($urandom);
                        1: x = LSF_X_BITS'($urandom_range(16)) - 16'sd8;
                        2: x = x0;
                        3: x = $urandom_range(1) ? x0 : x0 + 16'sd1;
                        default: x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    endcase
                    y = ($urandom_range(2) == 0)
                        ? LSF_Y_BITS'($urandom_range(200)) - 24'sd100
                        : LSF_Y_BITS'($urandom);
                    send_point(x, y, k == len - 1);
                    sent++;
                end
            end
        end
    endtask

    // receiver: random pops, checked at the rising edge against the oldest fit owed
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_pop = ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_fit want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (fit_q.size() == 0) begin
                report_mismatch("unowed fit", o_slope, '0);
            end else begin
                want = fit_q.pop_front();
                if (o_slope !== want.slope)
                    report_mismatch("slope", o_slope, want.slope);
                if (o_intercept !== want.intercept)
                    report_mismatch("intercept", o_intercept, want.intercept);
                if (o_fit_status !== want.status)
                    report_mismatch("fit_status", LSF_OUT_W'(o_fit_status),
                                    LSF_OUT_W'(want.status));
            end
        end
    end

    // hard stop: generous against slow serial fits and long stalls
    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int i;
        i_rst_n      = 1'b0;
        i_push       = 1'b0;
        i_pop        = 1'b0;
        i_x_value    = '0;
        i_y_value    = '0;
        i_last_point = 1'b0;
        err_count    = 0;
        set_count    = 0;
        sum_x        = '0;
        sum_y        = '0;
        sum_xx       = '0;
        sum_xy       = '0;
        set_dropped  = 1'b0;
        snd_idle_pct = 17;
        rcv_idle_pct = 83;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < NUM_DIR; i++) begin
            send_point(DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].last);
            // trivially known fits replace the computed one
            if (DIR_TAB[i].known)
                fit_q[fit_q.size() - 1] = DIR_TAB[i].fit;
        end
        send_sets(600);

        // sender holds off until the block has drained completely
        i_push = 1'b0;
        wait (fit_q.size() == 0);
        @(negedge i_clk);
        snd_idle_pct = 83;
        rcv_idle_pct = 17;
        send_sets(600);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_sets(680);
        i_push = 1'b0;

        wait (fit_q.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/lsf_pkg.sv
hdl/lsf_queue.sv
hdl/lsf_front.sv
hdl/lsf_back.sv
hdl/least_squares_line_fit.sv
hdl/lsf_checker.sv
test/least_squares_line_fit_tb.sv
